// ----- hdl/c2d_pkg.sv -----
// shared types, register codes and defaults for the rgb 2d convolution block
package c2d_pkg;

    localparam int C2D_MAX_WIDTH  = 2048;
    localparam int C2D_MAX_HEIGHT = 2048;
    localparam int C2D_KERNEL_MAX = 5;
    localparam int C2D_COEF_BITS  = 12;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 60;
    localparam int COEF_ROWS = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW4      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_CONTROL = 3'd7;

    localparam logic [CFG_W-1:0] RST_COEF_ROW2    = 60'd256;
    localparam logic [11:0]      RST_FRAME_WIDTH  = 12'd640;
    localparam logic [11:0]      RST_FRAME_HEIGHT = 12'd480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_GATHER,
        ST_FLUSH,
        ST_COMBINE,
        ST_DIVIDE,
        ST_EMIT
    } c2d_state_t;

    typedef struct packed {
        logic clear;
        logic pass_en;
    } c2d_ctl_t;

endpackage

// ----- hdl/c2d_cell.sv -----
// one kernel-row cell: multiply-accumulate of its row taps, then sum passing down the chain
module c2d_cell import c2d_pkg::*; #(
    parameter int COEF_BITS = C2D_COEF_BITS,
    parameter int IDX       = 0,
    parameter int TW        = 1,
    parameter int SUM_W     = 32,
    parameter int KS_W      = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  c2d_ctl_t                    ctl,
    input  logic [TW-1:0]               pass_step,
    input  logic                        tap_v_in,
    input  logic [TW-1:0]               tap_row_in,
    input  logic signed [COEF_BITS-1:0] tap_coef_in,
    input  logic [3*PIX_W-1:0]          tap_pix_in,
    output logic                        tap_v_out,
    output logic [TW-1:0]               tap_row_out,
    output logic signed [COEF_BITS-1:0] tap_coef_out,
    output logic [3*PIX_W-1:0]          tap_pix_out,
    input  logic signed [SUM_W-1:0]     sum_r_in,
    input  logic signed [SUM_W-1:0]     sum_g_in,
    input  logic signed [SUM_W-1:0]     sum_b_in,
    input  logic signed [KS_W-1:0]      sum_k_in,
    output logic signed [SUM_W-1:0]     sum_r_out,
    output logic signed [SUM_W-1:0]     sum_g_out,
    output logic signed [SUM_W-1:0]     sum_b_out,
    output logic signed [KS_W-1:0]      sum_k_out
);

    localparam int PROD_W = COEF_BITS + PIX_W;

    logic                        tap_v_reg;
    logic [TW-1:0]               tap_row_reg;
    logic signed [COEF_BITS-1:0] tap_coef_reg;
    logic [3*PIX_W-1:0]          tap_pix_reg;

    logic                        prod_v_reg;
    logic signed [PROD_W-1:0]    prod_r_reg, prod_g_reg, prod_b_reg;
    logic signed [COEF_BITS-1:0] prod_k_reg;

    logic signed [SUM_W-1:0]     acc_r_reg, acc_g_reg, acc_b_reg;
    logic signed [KS_W-1:0]      acc_k_reg;

    logic                        hit;
    logic                        pass_hit;
    logic signed [PROD_W:0]      full_r, full_g, full_b;

    assign hit      = tap_v_in && (tap_row_in == TW'(IDX));
    assign pass_hit = ctl.pass_en && (pass_step == TW'(IDX));

    assign full_r = tap_coef_in * $signed({1'b0, tap_pix_in[PIX_W-1:0]});
    assign full_g = tap_coef_in * $signed({1'b0, tap_pix_in[2*PIX_W-1:PIX_W]});
    assign full_b = tap_coef_in * $signed({1'b0, tap_pix_in[3*PIX_W-1:2*PIX_W]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
        end else begin
            tap_v_reg  <= tap_v_in;
            prod_v_reg <= hit;
        end
    end

    always_ff @(posedge aclk) begin
        tap_row_reg  <= tap_row_in;
        tap_coef_reg <= tap_coef_in;
        tap_pix_reg  <= tap_pix_in;
        prod_r_reg   <= full_r[PROD_W-1:0];
        prod_g_reg   <= full_g[PROD_W-1:0];
        prod_b_reg   <= full_b[PROD_W-1:0];
        prod_k_reg   <= tap_coef_in;
    end

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            acc_r_reg <= '0;
            acc_g_reg <= '0;
            acc_b_reg <= '0;
            acc_k_reg <= '0;
        end else if (prod_v_reg) begin
            acc_r_reg <= acc_r_reg + {{(SUM_W-PROD_W){prod_r_reg[PROD_W-1]}}, prod_r_reg};
            acc_g_reg <= acc_g_reg + {{(SUM_W-PROD_W){prod_g_reg[PROD_W-1]}}, prod_g_reg};
            acc_b_reg <= acc_b_reg + {{(SUM_W-PROD_W){prod_b_reg[PROD_W-1]}}, prod_b_reg};
            acc_k_reg <= acc_k_reg
                + {{(KS_W-COEF_BITS){prod_k_reg[COEF_BITS-1]}}, prod_k_reg};
        end else if (pass_hit) begin
            // fold the upstream partial sums into this row
            acc_r_reg <= acc_r_reg + sum_r_in;
            acc_g_reg <= acc_g_reg + sum_g_in;
            acc_b_reg <= acc_b_reg + sum_b_in;
            acc_k_reg <= acc_k_reg + sum_k_in;
        end
    end

    assign tap_v_out    = tap_v_reg;
    assign tap_row_out  = tap_row_reg;
    assign tap_coef_out = tap_coef_reg;
    assign tap_pix_out  = tap_pix_reg;
    assign sum_r_out    = acc_r_reg;
    assign sum_g_out    = acc_g_reg;
    assign sum_b_out    = acc_b_reg;
    assign sum_k_out    = acc_k_reg;

endmodule

// ----- hdl/c2d_div.sv -----
// iterative scale, round and clamp of the three channel sums, one quotient bit per cycle
module c2d_div import c2d_pkg::*; #(
    parameter int SUM_W = 32,
    parameter int KS_W  = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic                    norm,
    input  logic signed [SUM_W-1:0] sum_r,
    input  logic signed [SUM_W-1:0] sum_g,
    input  logic signed [SUM_W-1:0] sum_b,
    input  logic signed [KS_W-1:0]  ksum,
    output logic                    done,
    output logic [PIX_W-1:0]        res_r,
    output logic [PIX_W-1:0]        res_g,
    output logic [PIX_W-1:0]        res_b
);

    localparam int DEN_W = (KS_W > 9) ? KS_W : 9;
    localparam int NUM_W = SUM_W + 1;
    localparam int CW    = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 11;

    logic              busy_reg;
    logic              done_reg;
    logic [1:0]        ch_reg;
    logic [3:0]        stp_reg;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     dsh_reg;
    logic [PIX_W-1:0]  q_reg;
    logic [PIX_W-1:0]  res_reg [3];

    logic signed [SUM_W-1:0] sel;
    logic signed [NUM_W-1:0] num;
    logic [KS_W-1:0]         kabs;
    logic [DEN_W-1:0]        den;
    logic [CW-1:0]           n_val;
    logic [CW-1:0]           d_val;
    logic                    ge;
    logic [PIX_W-1:0]        q_bit;

    always_comb begin
        case (ch_reg)
            2'd0:    sel = sum_r;
            2'd1:    sel = sum_g;
            default: sel = sum_b;
        endcase
    end

    assign kabs  = ksum[KS_W-1] ? (~ksum + 1'b1) : ksum;
    assign num   = (norm && ksum[KS_W-1]) ? -{sel[SUM_W-1], sel} : {sel[SUM_W-1], sel};
    assign den   = norm ? DEN_W'(kabs) : DEN_W'(256);
    // round half away from zero: (2n + d) / 2d
    assign n_val = (CW'($unsigned(num)) << 1) + CW'(den);
    assign d_val = CW'(den) << 1;
    assign ge    = rem_reg >= dsh_reg;
    assign q_bit = {q_reg[PIX_W-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ch_reg   <= '0;
            stp_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                ch_reg   <= '0;
                stp_reg  <= '0;
            end else if (busy_reg) begin
                if (stp_reg == 4'd0) begin
                    if ((norm && ksum == '0) || num <= 0 || n_val >= (d_val << 8)) begin
                        if (ch_reg == 2'd2) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end else begin
                            ch_reg <= ch_reg + 1'b1;
                        end
                    end else begin
                        stp_reg <= 4'd1;
                    end
                end else if (stp_reg == 4'd8) begin
                    stp_reg <= '0;
                    if (ch_reg == 2'd2) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end else begin
                    stp_reg <= stp_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && !start) begin
            if (stp_reg == 4'd0) begin
                rem_reg <= n_val;
                dsh_reg <= d_val << 7;
                q_reg   <= '0;
                if (norm && ksum == '0) begin
                    res_reg[ch_reg] <= (sel > 0) ? 8'd255 : 8'd0;
                end else if (num <= 0) begin
                    res_reg[ch_reg] <= 8'd0;
                end else if (n_val >= (d_val << 8)) begin
                    res_reg[ch_reg] <= 8'd255;
                end
            end else begin
                if (ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                dsh_reg <= dsh_reg >> 1;
                q_reg   <= q_bit;
                if (stp_reg == 4'd8) begin
                    res_reg[ch_reg] <= q_bit;
                end
            end
        end
    end

    assign done  = done_reg;
    assign res_r = res_reg[0];
    assign res_g = res_reg[1];
    assign res_b = res_reg[2];

endmodule

// ----- hdl/conv2d_clamp_edge_rgb.sv -----
// rgb 2d convolution with clamp-to-edge borders: line store, cell chain and divider
//
// Pixels enter on the s_ stream in raster order, one request per pixel; s_tuser
// high marks a drain request that stands in for a pixel after the end of the frame.
// Filtered pixels leave on the m_ stream: m_tlast marks the last result of one
// request, m_tuser the last pixel of the frame. A request yields up to R+1 results
// (R = kernel radius); output row r appears while input row r+R arrives, and R
// rows of drain requests after the frame flush the bottom rows.
// The block works on one request at a time. For each result it reads the window taps
// from the line memory (one read port), empties the cell chain, folds the row sums
// down the chain, runs the shared divider channel by channel and loads the output
// register. The output register holds a result while m_tready is low; the block then
// waits before the next result and accepts no request until the last result is loaded.
// Reset (aresetn low, synchronous) restores the default registers (identity kernel,
// 640x480, no normalize) and clears the position counters but not the line memory. The
// user must write configuration on cfg_wr_en only while idle; the block does not enforce it.
module conv2d_clamp_edge_rgb import c2d_pkg::*; #(
    parameter int MAX_WIDTH  = C2D_MAX_WIDTH,
    parameter int MAX_HEIGHT = C2D_MAX_HEIGHT,
    parameter int KERNEL_MAX = C2D_KERNEL_MAX,
    parameter int COEF_BITS  = C2D_COEF_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // in_red, in_green, in_blue
    input  logic                 s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // out_red, out_green, out_blue
    output logic                 m_tlast,   // run_last
    output logic                 m_tuser    // frame_last
);

    localparam int RAD_CAP = (((KERNEL_MAX - 1) / 2) > 2) ? 2 : ((KERNEL_MAX - 1) / 2);
    localparam int NCELL   = 2 * RAD_CAP + 1;
    localparam int TW      = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int PSW     = $clog2(NCELL + 1);
    localparam int SLOT_W  = TW;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 3);
    localparam int CRD_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + 3;
    localparam int CMP_W   = 14;
    localparam int ADDR_W  = SLOT_W + COL_W;
    localparam int DEPTH   = NCELL << COL_W;
    localparam int NTAP    = NCELL * NCELL;
    localparam int SUM_W   = COEF_BITS + PIX_W + $clog2(NTAP) + 1;
    localparam int KS_W    = COEF_BITS + $clog2(NTAP) + 1;
    localparam int FL_W    = $clog2(NCELL + 3);
    localparam int ROWV_W  = CFG_W + NCELL * COEF_BITS;
    localparam int ROW_OFS = 2 - RAD_CAP;

    c2d_state_t state_reg, state_next;

    logic [CFG_W-1:0] coef_reg [COEF_ROWS];
    logic [11:0]      fw_reg, fh_reg;
    logic [2:0]       fc_reg;

    logic [ROW_W-1:0]  in_row_reg;
    logic [COL_W-1:0]  in_col_reg;
    logic [SLOT_W-1:0] in_slot_reg;
    logic              item_drain_reg;
    logic [23:0]       item_pix_reg;

    logic [ROW_W-1:0]  orow_reg;
    logic [SLOT_W-1:0] oslot_reg;
    logic [COL_W-1:0]  col_reg, hi_reg;
    logic [TW-1:0]     tr_reg, tc_reg;
    logic [FL_W-1:0]   fl_cnt_reg;
    logic [PSW-1:0]    pstep_reg;

    logic              rd_v_reg;
    logic [TW-1:0]     rd_tr_reg, rd_tc_reg;
    logic [23:0]       rd_data_reg;
    logic [23:0]       line_mem [DEPTH];

    logic              m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [23:0]       m_tdata_reg;

    // effective geometry
    logic [CMP_W-1:0]        fw_ext, fh_ext, w_sat, h_sat;
    logic [1:0]              rad_u;
    logic signed [CRD_W-1:0] w_s, h_s, rad_s, ncell_s;
    logic                    norm;

    // request setup
    logic signed [CRD_W-1:0] row_s, col_s, r0, c0, r1, c1, lo_s, hi_s, os_s, orow_s;
    logic [SLOT_W-1:0]       s0, s1;
    logic                    restart, is_frame, emit;

    // window read
    logic signed [CRD_W-1:0] rowx, colx, drow, slot_t;
    logic [ADDR_W-1:0]       rd_addr, wr_addr;
    logic [TW-1:0]           tap_max;
    logic                    gather_last;

    // tap formation
    logic [TW:0]                 tap_row_w;
    logic [TW-1:0]               tap_row;
    logic [2:0]                  creg_idx;
    logic [ROWV_W-1:0]           coef_rowv;
    logic signed [COEF_BITS-1:0] tap_coef;

    // control
    logic     out_free, mem_we, div_start, div_done, out_load;
    c2d_ctl_t cell_ctl;

    logic                        ch_v    [NCELL+1];
    logic [TW-1:0]               ch_row  [NCELL+1];
    logic signed [COEF_BITS-1:0] ch_coef [NCELL+1];
    logic [23:0]                 ch_pix  [NCELL+1];
    logic signed [SUM_W-1:0]     ch_r    [NCELL+1];
    logic signed [SUM_W-1:0]     ch_g    [NCELL+1];
    logic signed [SUM_W-1:0]     ch_b    [NCELL+1];
    logic signed [KS_W-1:0]      ch_k    [NCELL+1];
    logic [PIX_W-1:0]            res_r, res_g, res_b;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= '0;
            coef_reg[1] <= '0;
            coef_reg[2] <= RST_COEF_ROW2;
            coef_reg[3] <= '0;
            coef_reg[4] <= '0;
            fw_reg      <= RST_FRAME_WIDTH;
            fh_reg      <= RST_FRAME_HEIGHT;
            fc_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_COEF_ROW0:      coef_reg[0] <= cfg_wdata;
                CFG_COEF_ROW1:      coef_reg[1] <= cfg_wdata;
                CFG_COEF_ROW2:      coef_reg[2] <= cfg_wdata;
                CFG_COEF_ROW3:      coef_reg[3] <= cfg_wdata;
                CFG_COEF_ROW4:      coef_reg[4] <= cfg_wdata;
                CFG_FRAME_WIDTH:    fw_reg      <= cfg_wdata[11:0];
                CFG_FRAME_HEIGHT:   fh_reg      <= cfg_wdata[11:0];
                CFG_FILTER_CONTROL: fc_reg      <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    assign fw_ext  = {2'b00, fw_reg};
    assign fh_ext  = {2'b00, fh_reg};
    assign w_sat   = (fw_ext == '0) ? CMP_W'(1)
                   : (fw_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : fw_ext;
    assign h_sat   = (fh_ext == '0) ? CMP_W'(1)
                   : (fh_ext > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : fh_ext;
    assign rad_u   = (fc_reg[2:1] > 2'(RAD_CAP)) ? 2'(RAD_CAP) : fc_reg[2:1];
    assign w_s     = $signed(CRD_W'(w_sat));
    assign h_s     = $signed(CRD_W'(h_sat));
    assign rad_s   = $signed(CRD_W'(rad_u));
    assign ncell_s = $signed(CRD_W'(NCELL));
    assign norm    = fc_reg[0];

    // position of this request, with restart after a geometry change
    always_comb begin
        row_s    = $signed(CRD_W'(in_row_reg));
        col_s    = $signed(CRD_W'(in_col_reg));
        restart  = (col_s >= w_s) || (row_s >= h_s + rad_s);
        r0       = restart ? '0 : row_s;
        c0       = restart ? '0 : col_s;
        s0       = restart ? '0 : in_slot_reg;
        is_frame = r0 < h_s;
        emit     = (r0 >= rad_s) && ((c0 >= rad_s) || (c0 == w_s - 1));
        lo_s     = (c0 >= rad_s) ? c0 - rad_s : '0;
        hi_s     = (c0 == w_s - 1) ? w_s - 1 : c0 - rad_s;
        orow_s   = r0 - rad_s;
        os_s     = $signed(CRD_W'(s0)) - rad_s;
        if (os_s < 0) begin
            os_s = os_s + ncell_s;
        end
        c1 = c0 + 1;
        r1 = r0;
        s1 = s0;
        if (c1 >= w_s) begin
            c1 = '0;
            r1 = r0 + 1;
            s1 = (s0 == SLOT_W'(NCELL - 1)) ? '0 : s0 + 1'b1;
            if (r1 >= h_s + rad_s) begin
                r1 = '0;
                s1 = '0;
            end
        end
    end

    // clamped window address of the current tap
    always_comb begin
        rowx = $signed(CRD_W'(orow_reg)) + $signed(CRD_W'(tr_reg)) - rad_s;
        if (rowx < 0) begin
            rowx = '0;
        end
        if (rowx > h_s - 1) begin
            rowx = h_s - 1;
        end
        colx = $signed(CRD_W'(col_reg)) + $signed(CRD_W'(tc_reg)) - rad_s;
        if (colx < 0) begin
            colx = '0;
        end
        if (colx > w_s - 1) begin
            colx = w_s - 1;
        end
        drow   = rowx - $signed(CRD_W'(orow_reg));
        slot_t = $signed(CRD_W'(oslot_reg)) + drow;
        if (slot_t < 0) begin
            slot_t = slot_t + ncell_s;
        end
        if (slot_t >= ncell_s) begin
            slot_t = slot_t - ncell_s;
        end
    end

    assign rd_addr     = {slot_t[SLOT_W-1:0], colx[COL_W-1:0]};
    assign wr_addr     = {s0, c0[COL_W-1:0]};
    assign tap_max     = TW'({rad_u, 1'b0});
    assign gather_last = (tr_reg == tap_max) && (tc_reg == tap_max);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (is_frame && item_drain_reg) begin
                    state_next = ST_IDLE;
                end else if (emit) begin
                    state_next = ST_GATHER;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_GATHER: begin
                if (gather_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (fl_cnt_reg == FL_W'(NCELL + 1)) begin
                    state_next = ST_COMBINE;
                end
            end
            ST_COMBINE: begin
                if (pstep_reg == PSW'(NCELL)) begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = (col_reg == hi_reg) ? ST_IDLE : ST_GATHER;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready         = state_reg == ST_IDLE;
        mem_we           = (state_reg == ST_SETUP) && is_frame && !item_drain_reg;
        cell_ctl.clear   = (state_reg == ST_GATHER) && (tr_reg == '0) && (tc_reg == '0);
        cell_ctl.pass_en = (state_reg == ST_COMBINE) && (pstep_reg != PSW'(NCELL));
        div_start        = (state_reg == ST_COMBINE) && (pstep_reg == PSW'(NCELL));
        out_load         = (state_reg == ST_EMIT) && out_free;
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            in_slot_reg <= '0;
            rd_v_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg  <= state_reg == ST_GATHER;
            if (state_reg == ST_SETUP) begin
                if (is_frame && item_drain_reg) begin
                    in_row_reg  <= r0[ROW_W-1:0];
                    in_col_reg  <= c0[COL_W-1:0];
                    in_slot_reg <= s0;
                end else begin
                    in_row_reg  <= r1[ROW_W-1:0];
                    in_col_reg  <= c1[COL_W-1:0];
                    in_slot_reg <= s1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            item_drain_reg <= s_tuser;
            item_pix_reg   <= s_tdata;
        end
        if (state_reg == ST_SETUP) begin
            orow_reg  <= orow_s[ROW_W-1:0];
            oslot_reg <= os_s[SLOT_W-1:0];
            col_reg   <= lo_s[COL_W-1:0];
            hi_reg    <= hi_s[COL_W-1:0];
            tr_reg    <= '0;
            tc_reg    <= '0;
        end else if (state_reg == ST_GATHER) begin
            if (tc_reg == tap_max) begin
                tc_reg <= '0;
                tr_reg <= tr_reg + 1'b1;
            end else begin
                tc_reg <= tc_reg + 1'b1;
            end
            fl_cnt_reg <= '0;
        end else if (state_reg == ST_FLUSH) begin
            fl_cnt_reg <= fl_cnt_reg + 1'b1;
            pstep_reg  <= PSW'(1);
        end else if (state_reg == ST_COMBINE) begin
            if (pstep_reg != PSW'(NCELL)) begin
                pstep_reg <= pstep_reg + 1'b1;
            end
        end else if (out_load) begin
            col_reg <= col_reg + 1'b1;
            tr_reg  <= '0;
            tc_reg  <= '0;
        end
        rd_tr_reg <= tr_reg;
        rd_tc_reg <= tc_reg;
    end

    // line memory: ring of rows, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[wr_addr] <= item_pix_reg;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    // kernel row of the tap picks the cell and the coefficient register
    assign tap_row_w = {1'b0, rd_tr_reg} + (TW + 1)'(2'(RAD_CAP) - rad_u);
    assign tap_row   = tap_row_w[TW-1:0];
    assign creg_idx  = 3'(tap_row) + 3'(ROW_OFS);
    assign coef_rowv = {{(ROWV_W - CFG_W){1'b0}}, coef_reg[creg_idx]};
    assign tap_coef  = $signed(coef_rowv[rd_tc_reg * COEF_BITS +: COEF_BITS]);

    assign ch_v[0]    = rd_v_reg;
    assign ch_row[0]  = tap_row;
    assign ch_coef[0] = tap_coef;
    assign ch_pix[0]  = rd_data_reg;
    assign ch_r[0]    = '0;
    assign ch_g[0]    = '0;
    assign ch_b[0]    = '0;
    assign ch_k[0]    = '0;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        c2d_cell #(
            .COEF_BITS (COEF_BITS),
            .IDX       (i),
            .TW        (TW),
            .SUM_W     (SUM_W),
            .KS_W      (KS_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl          (cell_ctl),
            .pass_step    (pstep_reg[TW-1:0]),
            .tap_v_in     (ch_v[i]),
            .tap_row_in   (ch_row[i]),
            .tap_coef_in  (ch_coef[i]),
            .tap_pix_in   (ch_pix[i]),
            .tap_v_out    (ch_v[i+1]),
            .tap_row_out  (ch_row[i+1]),
            .tap_coef_out (ch_coef[i+1]),
            .tap_pix_out  (ch_pix[i+1]),
            .sum_r_in     (ch_r[i]),
            .sum_g_in     (ch_g[i]),
            .sum_b_in     (ch_b[i]),
            .sum_k_in     (ch_k[i]),
            .sum_r_out    (ch_r[i+1]),
            .sum_g_out    (ch_g[i+1]),
            .sum_b_out    (ch_b[i+1]),
            .sum_k_out    (ch_k[i+1])
        );
    end

    c2d_div #(
        .SUM_W (SUM_W),
        .KS_W  (KS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .norm    (norm),
        .sum_r   (ch_r[NCELL]),
        .sum_g   (ch_g[NCELL]),
        .sum_b   (ch_b[NCELL]),
        .ksum    (ch_k[NCELL]),
        .done    (div_done),
        .res_r   (res_r),
        .res_g   (res_g),
        .res_b   (res_b)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {res_b, res_g, res_r};
            m_tlast_reg <= col_reg == hi_reg;
            m_tuser_reg <= ($signed(CRD_W'(orow_reg)) == h_s - 1)
                        && ($signed(CRD_W'(col_reg)) == w_s - 1);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
